[rtl/dsd_pkg.sv]
// ----------------------------------------------------------------------------
// dsd_pkg: shared types and constants for date_subtract_days
// Field widths, month-length table, month step function and control types.
// ----------------------------------------------------------------------------
package dsd_pkg;

   localparam int MONTH_W         = 4;
   localparam int DAY_W           = 5;
   localparam int YEAR_W          = 7;
   localparam int DAYS_W          = 16;
   localparam int COUNT_WIDTH_DEF = 16;

   localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
   localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
   localparam logic [YEAR_W-1:0]  YEAR_MAX  = 7'd99;

   typedef struct packed {
      logic [MONTH_W-1:0] month;
      logic [DAY_W-1:0]   day;
      logic [YEAR_W-1:0]  year;
   } date_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_LAST
   } state_type;

   typedef struct packed {
      logic load;
      logic step;
      logic finish;
   } dp_ctrl_type;

   typedef struct packed {
      logic more;
   } dp_stat_type;

   // Fixed month lengths, February always 28 days; month 0 reads as 0.
   function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
      logic [DAY_W-1:0] len;
      case (m)
         4'd1:    len = 5'd31;
         4'd2:    len = 5'd28;
         4'd3:    len = 5'd31;
         4'd4:    len = 5'd30;
         4'd5:    len = 5'd31;
         4'd6:    len = 5'd30;
         4'd7:    len = 5'd31;
         4'd8:    len = 5'd31;
         4'd9:    len = 5'd30;
         4'd10:   len = 5'd31;
         4'd11:   len = 5'd30;
         4'd12:   len = 5'd31;
         default: len = 5'd0;
      endcase
      return len;
   endfunction

   // Move to the last day of the previous month.
   function automatic date_type back_one_month(input date_type x);
      date_type r;
      r = x;
      if (x.month <= MONTH_JAN) begin
         r.month = MONTH_DEC;
         r.year  = (x.year == '0) ? YEAR_MAX : x.year - 7'd1;
      end else if (x.month > MONTH_DEC) begin
         r.month = MONTH_DEC;
      end else begin
         r.month = x.month - 4'd1;
      end
      r.day = month_len(r.month);
      return r;
   endfunction

endpackage

[rtl/dsd_req_if.sv]
// ----------------------------------------------------------------------------
// dsd_req_if: request channel
// Valid/ready channel carrying the finish date and the day count.
// ----------------------------------------------------------------------------
interface dsd_req_if
   import dsd_pkg::*;
;
   logic                valid;
   logic                ready;
   logic [MONTH_W-1:0]  finish_month;
   logic [DAY_W-1:0]    finish_day;
   logic [YEAR_W-1:0]   finish_year;
   logic [DAYS_W-1:0]   days_back;

   modport source (output valid, finish_month, finish_day, finish_year, days_back,
                   input ready);
   modport sink   (input valid, finish_month, finish_day, finish_year, days_back,
                   output ready);
endinterface

[rtl/dsd_rsp_if.sv]
// ----------------------------------------------------------------------------
// dsd_rsp_if: response channel
// Valid/ready channel carrying the start date.
// ----------------------------------------------------------------------------
interface dsd_rsp_if
   import dsd_pkg::*;
;
   logic                valid;
   logic                ready;
   logic [MONTH_W-1:0]  start_month;
   logic [DAY_W-1:0]    start_day;
   logic [YEAR_W-1:0]   start_year;

   modport source (output valid, start_month, start_day, start_year, input ready);
   modport sink   (input valid, start_month, start_day, start_year, output ready);
endinterface

[rtl/dsd_datapath.sv]
// ----------------------------------------------------------------------------
// dsd_datapath: working date, remaining count and shared subtractor
// One subtractor serves both the month test and the final day subtract.
// ----------------------------------------------------------------------------
module dsd_datapath
   import dsd_pkg::*;
#(
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  dp_ctrl_type       ctrl,
   input  date_type          load_date,
   input  logic [DAYS_W-1:0] load_days,
   output dp_stat_type       stat,
   output date_type          fin_date
);

   localparam int SUB_W = ((COUNT_WIDTH > DAY_W) ? COUNT_WIDTH : DAY_W) + 1;

   date_type               date_ff, date_in;
   logic [COUNT_WIDTH-1:0] left_ff, left_in;
   logic [SUB_W-1:0]       diff;
   logic [DAY_W-1:0]       day_rem;
   date_type               rem_date;

   // left - day; positive means the walk goes back another month
   assign diff      = SUB_W'(left_ff) - SUB_W'(date_ff.day);
   assign stat.more = !diff[SUB_W-1] && (diff != '0);

   // day >= left here, so day - left fits the day field
   assign day_rem = DAY_W'(SUB_W'(0) - diff);

   always_comb begin
      rem_date     = date_ff;
      rem_date.day = day_rem;
      fin_date     = (day_rem == '0) ? back_one_month(rem_date) : rem_date;
   end

   always_comb begin
      date_in = date_ff;
      left_in = left_ff;
      if (ctrl.load) begin
         date_in = load_date;
         left_in = COUNT_WIDTH'(load_days);
      end else if (ctrl.step) begin
         date_in = back_one_month(date_ff);
         left_in = COUNT_WIDTH'(diff);
      end
   end

   always_ff @(posedge clock) begin
      date_ff <= date_in;
      left_ff <= left_in;
   end

   // A step from a finish day of zero leaves the count as it is.
   a_left_shrinks: assert property (@(posedge clock) disable iff (reset)
      ctrl.step |=> left_ff <= $past(left_ff))
      else $error("remaining count grew on a month step");

   a_step_month_valid: assert property (@(posedge clock) disable iff (reset)
      ctrl.step |=> (date_ff.month >= MONTH_JAN && date_ff.month <= MONTH_DEC))
      else $error("month out of range after a month step");

   a_final_day_nonzero: assert property (@(posedge clock) disable iff (reset)
      ctrl.finish |-> fin_date.day != '0)
      else $error("final day is zero");

endmodule

[rtl/dsd_ctrl.sv]
// ----------------------------------------------------------------------------
// dsd_ctrl: sequencer for the month walk
// Load, step back one month per cycle while the count exceeds the day, finish.
// ----------------------------------------------------------------------------
module dsd_ctrl
   import dsd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        rsp_busy,
   input  dp_stat_type stat,
   output logic        req_ready,
   output dp_ctrl_type ctrl
);

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_WALK;
         end
         ST_WALK: begin
            if (!stat.more) state_in = ST_LAST;
         end
         ST_LAST: begin
            if (!rsp_busy) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready   = 1'b0;
      ctrl        = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            ctrl.load = req_valid;
         end
         ST_WALK: begin
            ctrl.step = stat.more;
         end
         ST_LAST: begin
            ctrl.finish = !rsp_busy;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[rtl/date_subtract_days.sv]
// ----------------------------------------------------------------------------
// date_subtract_days: finish date minus a day count, no leap years
// Walks back one month per cycle on a shared subtractor; output register.
// ----------------------------------------------------------------------------
// Usage:
//   req_bus carries one beat per request: finish month, day, two-digit year
//   and the count of days to go back (low COUNT_WIDTH bits used). rsp_bus
//   returns one beat per request: the start month, day and year.
//   After a request beat is taken the block walks back one month per cycle
//   while the remaining count is larger than the current day, then sees
//   that the walk is done and moves to its final state, where the final
//   day subtract and the day-zero fixup load the output register. The
//   next request is taken in the cycle after the response is loaded; no
//   new request is taken while one is in the walk. With a 16-bit count a
//   request steps back fewer than about 2340 months; the month-step loop
//   through the single subtractor sets how long a request takes.
//   req_bus.ready is high only while the sequencer is idle.
//   Reset (synchronous) returns the sequencer to idle and drops any pending
//   response. When the receiver stalls, the response beat holds in the
//   output register; the block may take and walk the next request meanwhile
//   and waits at the end until the output register is free.
// ----------------------------------------------------------------------------
module date_subtract_days
   import dsd_pkg::*;
#(
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
   input  logic         clock,
   input  logic         reset,
   dsd_req_if.sink      req_bus,
   dsd_rsp_if.source    rsp_bus
);

   dp_ctrl_type ctrl;
   dp_stat_type stat;
   date_type    load_date;
   date_type    fin_date;
   logic        rsp_busy;

   logic        rsp_valid_ff, rsp_valid_in;
   date_type    rsp_date_ff, rsp_date_in;

   // Pack the request beat into the working date.
   assign load_date.month = req_bus.finish_month;
   assign load_date.day   = req_bus.finish_day;
   assign load_date.year  = req_bus.finish_year;

   // Hold the result until the sink takes it.
   assign rsp_busy = rsp_valid_ff && !rsp_bus.ready;

   dsd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .rsp_busy  (rsp_busy),
      .stat      (stat),
      .req_ready (req_bus.ready),
      .ctrl      (ctrl)
   );

   dsd_datapath #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ctrl),
      .load_date (load_date),
      .load_days (req_bus.days_back),
      .stat      (stat),
      .fin_date  (fin_date)
   );

   // Output register: load on finish, drop valid once the beat is taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_date_in  = rsp_date_ff;
      if (ctrl.finish) begin
         rsp_valid_in = 1'b1;
         rsp_date_in  = fin_date;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_date_ff <= rsp_date_in;
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.start_month = rsp_date_ff.month;
   assign rsp_bus.start_day   = rsp_date_ff.day;
   assign rsp_bus.start_year  = rsp_date_ff.year;

endmodule
